FILE: hw/rtl/ntwa_pkg.sv
package ntwa_pkg;

    localparam int MAX_NEIGHBORS = 16;
    localparam int IDX_W         = $clog2(MAX_NEIGHBORS);
    localparam int CNT_W         = $clog2(MAX_NEIGHBORS + 1);

    // result field widths
    localparam int COUNT_FW   = 5;
    localparam int SLOT_FW    = 4;
    localparam int EVICTED_FW = 5;

    localparam logic OP_RECEIVE = 1'b0;
    localparam logic OP_AGE     = 1'b1;

    typedef struct packed {
        logic [7:0]  neighbors;
        logic [15:0] distance;
        logic [31:0] stamp;
        logic [7:0]  id;
    } ntwa_entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        ntwa_entry_t      wdata;
        logic [IDX_W-1:0] raddr;
    } ntwa_store_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_AGE_RD,
        ST_AGE_CHK,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_DONE
    } ntwa_state_t;

endpackage

FILE: hw/rtl/ntwa_store.sv
module ntwa_store (
    input  logic                     aclk,
    input  ntwa_pkg::ntwa_store_req_t req,
    output ntwa_pkg::ntwa_entry_t     rd_data
);

    ntwa_pkg::ntwa_entry_t mem [ntwa_pkg::MAX_NEIGHBORS];
    ntwa_pkg::ntwa_entry_t rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data_reg <= mem[req.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/neighbor_table_with_aging_unit.sv
// channel   dir  handshake          tdata / tuser
// s_        in   s_tvalid/s_tready  tdata: now, sender_id, distance, sender_neighbors; tuser: op
// m_        out  m_tvalid/m_tready  tdata: table_count, slot, hit, evicted
// cfg_      in   cfg_wr_en          cfg_wr_data: age_timeout
//
// receive word: one entry read per cycle from the store
// age word: a read and a check per entry checked, plus a move read and write per entry evicted
// the single read port of the entry store paces both kinds of word
// reset clears the entry count and loads a timeout of 32; entry contents are not cleared
// a finished result sits in the output register; a new word is taken meanwhile, and
// only the hand-over of its own result waits on m_tready
module neighbor_table_with_aging_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // now[31:0], sender_id[39:32], distance[55:40],
                                   // sender_neighbors[63:56]
    input  logic [0:0]  s_tuser,   // op[0]
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // table_count[4:0], slot[8:5], hit[9], evicted[14:10],
                                   // zero[15]
    // configuration
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    localparam int IW = ntwa_pkg::IDX_W;
    localparam int CW = ntwa_pkg::CNT_W;

    ntwa_pkg::ntwa_state_t state_reg, state_next;

    // latched input word
    logic [31:0] now_reg, now_next;
    logic [7:0]  sid_reg, sid_next;
    logic [15:0] dist_reg, dist_next;
    logic [7:0]  nbrs_reg, nbrs_next;

    logic [CW-1:0] count_reg, count_next;     // valid entries
    logic [CW-1:0] idx_reg, idx_next;         // scan index / sweep position
    logic          pend_reg, pend_next;       // a read is in flight during the scan
    logic [IW-1:0] pidx_reg, pidx_next;       // index of that read
    logic [CW-1:0] evict_reg, evict_next;
    logic [IW-1:0] slot_reg, slot_next;
    logic          hit_reg, hit_next;
    logic [15:0]   timeout_reg;

    logic          m_tvalid_reg, m_tvalid_next;
    logic [15:0]   m_tdata_reg, m_tdata_next;

    ntwa_pkg::ntwa_store_req_t req;
    ntwa_pkg::ntwa_entry_t     rd;
    logic [31:0]               age;

    ntwa_store u_store (
        .aclk    (aclk),
        .req     (req),
        .rd_data (rd)
    );

    assign age = now_reg - rd.stamp;   // wraps modulo 2^32

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ntwa_pkg::ST_IDLE;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            timeout_reg  <= 16'd32;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        now_reg     <= now_next;
        sid_reg     <= sid_next;
        dist_reg    <= dist_next;
        nbrs_reg    <= nbrs_next;
        idx_reg     <= idx_next;
        pidx_reg    <= pidx_next;
        evict_reg   <= evict_next;
        slot_reg    <= slot_next;
        hit_reg     <= hit_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        state_next    = state_reg;
        now_next      = now_reg;
        sid_next      = sid_reg;
        dist_next     = dist_reg;
        nbrs_next     = nbrs_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pidx_next     = pidx_reg;
        evict_next    = evict_reg;
        slot_next     = slot_reg;
        hit_next      = hit_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s_tready      = 1'b0;

        req.we              = 1'b0;
        req.waddr           = '0;
        req.wdata.id        = sid_reg;
        req.wdata.stamp     = now_reg;
        req.wdata.distance  = dist_reg;
        req.wdata.neighbors = nbrs_reg;
        req.raddr           = '0;

        unique case (state_reg)
            ntwa_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    now_next   = s_tdata[31:0];
                    sid_next   = s_tdata[39:32];
                    dist_next  = s_tdata[55:40];
                    nbrs_next  = s_tdata[63:56];
                    evict_next = '0;
                    slot_next  = '0;
                    hit_next   = 1'b0;
                    pend_next  = 1'b0;
                    if (s_tuser[0] == ntwa_pkg::OP_AGE) begin
                        idx_next   = count_reg;
                        state_next = ntwa_pkg::ST_AGE_RD;
                    end else begin
                        idx_next   = '0;
                        state_next = ntwa_pkg::ST_SCAN;
                    end
                end
            end

            // one read issued per cycle, the previous one compared
            ntwa_pkg::ST_SCAN: begin
                priority if (pend_reg && rd.id == sid_reg) begin
                    hit_next   = 1'b1;
                    slot_next  = pidx_reg;
                    req.we     = 1'b1;
                    req.waddr  = pidx_reg;
                    pend_next  = 1'b0;
                    state_next = ntwa_pkg::ST_DONE;
                end else if (idx_reg == count_reg) begin
                    pend_next = 1'b0;
                    if (count_reg < CW'(ntwa_pkg::MAX_NEIGHBORS)) begin
                        slot_next  = idx_reg[IW-1:0];
                        req.waddr  = idx_reg[IW-1:0];
                        count_next = count_reg + 1'b1;
                    end else begin
                        // full table: last entry is overwritten
                        slot_next = IW'(ntwa_pkg::MAX_NEIGHBORS - 1);
                        req.waddr = IW'(ntwa_pkg::MAX_NEIGHBORS - 1);
                    end
                    req.we     = 1'b1;
                    state_next = ntwa_pkg::ST_DONE;
                end else begin
                    req.raddr = idx_reg[IW-1:0];
                    pend_next = 1'b1;
                    pidx_next = idx_reg[IW-1:0];
                    idx_next  = idx_reg + 1'b1;
                end
            end

            // sweep from the top entry down
            ntwa_pkg::ST_AGE_RD: begin
                if (idx_reg == '0) begin
                    state_next = ntwa_pkg::ST_DONE;
                end else begin
                    req.raddr  = IW'(idx_reg - 1'b1);
                    idx_next   = idx_reg - 1'b1;
                    state_next = ntwa_pkg::ST_AGE_CHK;
                end
            end

            ntwa_pkg::ST_AGE_CHK: begin
                if (age > {16'd0, timeout_reg}) begin
                    state_next = ntwa_pkg::ST_MOVE_RD;
                end else begin
                    state_next = ntwa_pkg::ST_AGE_RD;
                end
            end

            // fetch the last entry to fill the hole
            ntwa_pkg::ST_MOVE_RD: begin
                req.raddr  = IW'(count_reg - 1'b1);
                state_next = ntwa_pkg::ST_MOVE_WR;
            end

            ntwa_pkg::ST_MOVE_WR: begin
                req.we     = 1'b1;
                req.waddr  = idx_reg[IW-1:0];
                req.wdata  = rd;
                count_next = count_reg - 1'b1;
                evict_next = evict_reg + 1'b1;
                state_next = ntwa_pkg::ST_AGE_RD;
            end

            ntwa_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0,
                                     ntwa_pkg::EVICTED_FW'(evict_reg),
                                     hit_reg,
                                     ntwa_pkg::SLOT_FW'(slot_reg),
                                     ntwa_pkg::COUNT_FW'(count_reg)};
                    state_next    = ntwa_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = ntwa_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // table never holds more than its depth
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(ntwa_pkg::MAX_NEIGHBORS))
        else $error("entry count beyond table depth");

    // a move into a hole always drops the count by one
    a_move_drops_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ntwa_pkg::ST_MOVE_WR |=> count_reg == $past(count_reg) - 1'b1)
        else $error("eviction did not shrink the table");

    // a result never reports both a hit and evictions
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9] |-> m_tdata[14:10] == '0)
        else $error("hit and eviction in one result");

    // a taken word closes the input right after the accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input reopened right after accept");

endmodule
